FILE: design/alfs_pkg.sv
// Shared definitions for the APU length counter and frame sequencer.
// Holds register offsets, field widths and the length lookup table.
// No dependencies.
package alfs_pkg;

	localparam int PERIOD_W  = 11;
	localparam int LENGTH_W  = 8;
	localparam int ENABLE_W  = 5;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 8;
	localparam int DIVIDE_W  = 16;
	localparam int STEP_W    = 3;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 64;

	localparam logic [DIVIDE_W-1:0] FRAME_DIVIDE_RST = 16'd20545;

	localparam logic [ADDR_W-1:0] REG_P1_LO  = 5'd2;
	localparam logic [ADDR_W-1:0] REG_P1_HI  = 5'd3;
	localparam logic [ADDR_W-1:0] REG_P2_LO  = 5'd6;
	localparam logic [ADDR_W-1:0] REG_P2_HI  = 5'd7;
	localparam logic [ADDR_W-1:0] REG_TRI_LO = 5'd10;
	localparam logic [ADDR_W-1:0] REG_TRI_HI = 5'd11;
	localparam logic [ADDR_W-1:0] REG_STATUS = 5'd21;
	localparam logic [ADDR_W-1:0] REG_FRAME  = 5'd23;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [LENGTH_W-1:0] length_t;

	function automatic length_t len_lookup(input logic [4:0] idx);
		length_t v;
		case (idx)
			5'd0: v = 8'd10;
			5'd1: v = 8'd254;
			5'd2: v = 8'd20;
			5'd3: v = 8'd2;
			5'd4: v = 8'd40;
			5'd5: v = 8'd4;
			5'd6: v = 8'd80;
			5'd7: v = 8'd6;
			5'd8: v = 8'd160;
			5'd9: v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd36;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			5'd31: v = 8'd30;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/apu_length_and_frame_sequencer.sv
// Top level: APU period registers, pulse length counters and frame sequencer.
// Depends on alfs_pkg.
//
// channel   | handshake          | payload
// s_axis    | s_tvalid/s_tready  | tuser: cmd; tdata: reg_addr, write_data
// m_axis    | m_tvalid/m_tready  | tdata: irq_pulse .. irq_blocked
// cfg       | cfg_we             | cfg_wdata: frame_divide
//
// One item per cycle unless stalled; results appear in the cycle after acceptance.
// The state update and the result register load in the same cycle as accept.
// The one-deep result register stalls input only while it holds an untaken item.
// arst_n clears all state but the result data; frame_divide resets to 20545.
module apu_length_and_frame_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [alfs_pkg::DIVIDE_W-1:0]  cfg_wdata,  // frame_divide
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [alfs_pkg::S_TDATA_W-1:0] s_tdata,    // reg_addr[4:0], write_data[12:5]
	input  logic                           s_tuser,    // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [alfs_pkg::M_TDATA_W-1:0] m_tdata     // irq_pulse[0], pulse1_period[11:1],
	                                                   // pulse2_period[22:12],
	                                                   // triangle_period[33:23],
	                                                   // pulse1_remaining[41:34],
	                                                   // pulse2_remaining[49:42],
	                                                   // channel_enable[54:50],
	                                                   // seq_mode[55], irq_blocked[56]
);
	import alfs_pkg::*;

	logic [DIVIDE_W-1:0] divide_q, tick_q, tick_d;
	logic [STEP_W-1:0]   step_q, step_d, step_eff;
	period_t             p1_q, p2_q, tri_q, p1_d, p2_d, tri_d;
	length_t             len1_q, len2_q, len1_d, len2_d;
	logic [ENABLE_W-1:0] en_q, en_d;
	logic                mode_q, mode_d, inh_q, inh_d;
	logic                irq_d, fire, dec, accept;
	logic [ADDR_W-1:0]   addr;
	logic [DATA_W-1:0]   wdata;
	logic [M_TDATA_W-1:0] out_q;
	logic                 out_valid_q;

	assign addr     = s_tdata[ADDR_W-1:0];
	assign wdata    = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		tick_d   = tick_q;
		step_d   = step_q;
		p1_d     = p1_q;
		p2_d     = p2_q;
		tri_d    = tri_q;
		len1_d   = len1_q;
		len2_d   = len2_q;
		en_d     = en_q;
		mode_d   = mode_q;
		inh_d    = inh_q;
		irq_d    = 1'b0;
		fire     = tick_q >= divide_q;
		step_eff = (step_q > 3'd3) ? 3'd0 : step_q;
		dec      = (step_eff == 3'd1) || (step_eff == 3'd3);
		if (s_tuser == CMD_TICK) begin
			if (fire) begin
				tick_d = '0;
				step_d = step_eff + 3'd1;
				irq_d  = (step_eff == 3'd3) && !inh_q;
				if (dec) begin
					if (len1_q != '0) len1_d = len1_q - 8'd1;
					if (len2_q != '0) len2_d = len2_q - 8'd1;
				end
			end else begin
				tick_d = tick_q + 16'd1;
			end
		end else begin
			case (addr)
				REG_P1_LO: p1_d = {p1_q[10:8], wdata};
				REG_P1_HI: begin
					p1_d   = {wdata[2:0], p1_q[7:0]};
					len1_d = len_lookup(wdata[7:3]);
				end
				REG_P2_LO: p2_d = {p2_q[10:8], wdata};
				REG_P2_HI: begin
					p2_d   = {wdata[2:0], p2_q[7:0]};
					len2_d = len_lookup(wdata[7:3]);
				end
				REG_TRI_LO: tri_d = {tri_q[10:8], wdata};
				REG_TRI_HI: tri_d = {wdata[2:0], tri_q[7:0]};
				REG_STATUS: en_d = wdata[ENABLE_W-1:0];
				REG_FRAME: begin
					mode_d = wdata[7];
					inh_d  = wdata[6];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_q    <= FRAME_DIVIDE_RST;
			tick_q      <= '0;
			step_q      <= '0;
			p1_q        <= '0;
			p2_q        <= '0;
			tri_q       <= '0;
			len1_q      <= '0;
			len2_q      <= '0;
			en_q        <= '0;
			mode_q      <= 1'b0;
			inh_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) divide_q <= cfg_wdata;
			if (accept) begin
				tick_q <= tick_d;
				step_q <= step_d;
				p1_q   <= p1_d;
				p2_q   <= p2_d;
				tri_q  <= tri_d;
				len1_q <= len1_d;
				len2_q <= len2_d;
				en_q   <= en_d;
				mode_q <= mode_d;
				inh_q  <= inh_d;
			end
			if (accept) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= {7'd0, inh_d, mode_d, en_d, len2_d, len1_d, tri_d, p2_d, p1_d, irq_d};
		end
	end

endmodule

FILE: design/alfs_checker.sv
// Port-level checks for apu_length_and_frame_sequencer, bound to the top level.
// Depends on alfs_pkg.
module alfs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [alfs_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [alfs_pkg::M_TDATA_W-1:0] m_tdata
);
	import alfs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_write_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_WRITE |=> m_tvalid && !m_tdata[0])
		else $error("irq on a register write");

	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_WRITE && s_tdata[4:0] == REG_STATUS
		|=> m_tdata[54:50] == $past(s_tdata[9:5]))
		else $error("channel enable not loaded");

endmodule

bind apu_length_and_frame_sequencer alfs_checker u_alfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
